// File: hw/rtl/wbmp_pkg.sv
// Shared types and constants for the WBMP type 0 decoder.
// No dependencies; every other file of the block imports this package.
package wbmp_pkg;

    localparam int COORD_BITS = 19;
    localparam int DIM_BITS   = COORD_BITS + 1;
    localparam int CFG_BITS   = 20;
    localparam int CNT_BITS   = 4;
    localparam int IDX_BITS   = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [CFG_BITS-1:0] MAX_DIM_RESET = 20'h80000;

    typedef enum logic [1:0] {
        ERR_BAD_TYPE  = 2'd0,
        ERR_BAD_FIXED = 2'd1,
        ERR_ZERO_DIM  = 2'd2,
        ERR_TOO_LARGE = 2'd3
    } err_code_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_item_t;

    typedef struct packed {
        logic                  result_kind;
        logic [1:0]            error_code;
        logic                  pixel;
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic                  last_of_run;
        logic                  image_done;
    } out_item_t;

    // One queued unit of work: an error report or a pixel byte to unpack
    typedef struct packed {
        logic                  is_err;
        err_code_t             err_code;
        logic [7:0]            data_byte;
        logic [CNT_BITS-1:0]   count;
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic                  image_done;
    } wbmp_cmd_t;

endpackage

// File: hw/rtl/wbmp_front.sv
// Header parser: checks type/fixed bytes, accumulates dimensions and turns
// each pixel byte into one command. Depends on wbmp_pkg.
module wbmp_front import wbmp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_data,
    input  logic [DIM_BITS-1:0] limit,
    input  logic                q_full,
    output logic                q_push,
    output wbmp_cmd_t           q_cmd
);

    localparam int AW = DIM_BITS + 7;

    typedef enum logic [2:0] {
        PH_TYPE, PH_FIXED, PH_WIDTH, PH_HEIGHT, PH_PIXELS, PH_IDLE
    } phase_t;

    phase_t              phase_reg, phase_next, phase_eff;
    logic [DIM_BITS-1:0] width_reg, width_next, width_eff;
    logic [DIM_BITS-1:0] height_reg, height_next, height_eff;
    logic                flag_reg, flag_next, flag_eff;
    logic [DIM_BITS-1:0] col_reg, col_next, col_eff;
    logic [DIM_BITS-1:0] row_reg, row_next, row_eff;

    logic                accept;
    logic [DIM_BITS-1:0] acc_in, acc_sat, remaining, col_sum, row_inc;
    logic [AW-1:0]       acc_v;
    logic                over;
    logic [CNT_BITS-1:0] n_pix;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        // start of file restarts the parser before this byte is handled
        if (s_data.start_of_file) begin
            phase_eff  = PH_TYPE;
            width_eff  = '0;
            height_eff = '0;
            flag_eff   = 1'b0;
            col_eff    = '0;
            row_eff    = '0;
        end else begin
            phase_eff  = phase_reg;
            width_eff  = width_reg;
            height_eff = height_reg;
            flag_eff   = flag_reg;
            col_eff    = col_reg;
            row_eff    = row_reg;
        end

        acc_in  = (phase_eff == PH_WIDTH) ? width_eff : height_eff;
        acc_v   = {acc_in, s_data.data_byte[6:0]};
        over    = acc_v > {7'b0, limit};
        acc_sat = over ? limit : acc_v[DIM_BITS-1:0];

        remaining = width_eff - col_eff;
        n_pix     = (remaining >= DIM_BITS'(8)) ? CNT_BITS'(8) : remaining[CNT_BITS-1:0];
        col_sum   = col_eff + DIM_BITS'(n_pix);
        row_inc   = row_eff + DIM_BITS'(1);

        phase_next  = phase_eff;
        width_next  = width_eff;
        height_next = height_eff;
        flag_next   = flag_eff;
        col_next    = col_eff;
        row_next    = row_eff;
        q_push      = 1'b0;
        q_cmd       = '0;
        q_cmd.count = CNT_BITS'(1);

        unique case (phase_eff)
            PH_TYPE: begin
                if (s_data.data_byte != 8'd0) begin
                    q_push         = accept;
                    q_cmd.is_err   = 1'b1;
                    q_cmd.err_code = ERR_BAD_TYPE;
                    phase_next     = PH_IDLE;
                end else begin
                    phase_next = PH_FIXED;
                end
            end
            PH_FIXED: begin
                if (s_data.data_byte != 8'd0) begin
                    q_push         = accept;
                    q_cmd.is_err   = 1'b1;
                    q_cmd.err_code = ERR_BAD_FIXED;
                    phase_next     = PH_IDLE;
                end else begin
                    phase_next = PH_WIDTH;
                end
            end
            PH_WIDTH: begin
                width_next = acc_sat;
                flag_next  = flag_eff | over;
                if (!s_data.data_byte[7]) begin
                    phase_next = PH_HEIGHT;
                end
            end
            PH_HEIGHT: begin
                height_next = acc_sat;
                flag_next   = flag_eff | over;
                if (!s_data.data_byte[7]) begin
                    // zero check wins over the too-large check
                    if (width_eff == '0 || acc_sat == '0) begin
                        q_push         = accept;
                        q_cmd.is_err   = 1'b1;
                        q_cmd.err_code = ERR_ZERO_DIM;
                        phase_next     = PH_IDLE;
                    end else if (flag_eff | over) begin
                        q_push         = accept;
                        q_cmd.is_err   = 1'b1;
                        q_cmd.err_code = ERR_TOO_LARGE;
                        phase_next     = PH_IDLE;
                    end else begin
                        col_next   = '0;
                        row_next   = '0;
                        phase_next = PH_PIXELS;
                    end
                end
            end
            PH_PIXELS: begin
                q_push          = accept;
                q_cmd.data_byte = s_data.data_byte;
                q_cmd.count     = n_pix;
                q_cmd.column    = col_eff[COORD_BITS-1:0];
                q_cmd.row       = row_eff[COORD_BITS-1:0];
                if (col_sum >= width_eff) begin
                    if (row_inc >= height_eff) begin
                        q_cmd.image_done = 1'b1;
                        col_next         = col_sum;
                        phase_next       = PH_IDLE;
                    end else begin
                        row_next = row_inc;
                        col_next = '0;
                    end
                end else begin
                    col_next = col_sum;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TYPE;
            width_reg  <= '0;
            height_reg <= '0;
            flag_reg   <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            flag_reg   <= flag_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

// File: hw/rtl/wbmp_cmd_fifo.sv
// Small command queue between the parser and the pixel unpacker.
// Depends on wbmp_pkg for the command type and depth.
module wbmp_cmd_fifo import wbmp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  wbmp_cmd_t push_cmd,
    input  logic      pop,
    output wbmp_cmd_t head_cmd,
    output logic      not_empty,
    output logic      full
);

    wbmp_cmd_t              entries [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]       count_reg, count_next;

    assign head_cmd  = entries[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign full      = count_reg == (FIFO_AW+1)'(FIFO_DEPTH);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (FIFO_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/wbmp_back.sv
// Pixel unpacker: expands each queued command into results, one per cycle
// while the output is not stalled, into the output register. Depends on wbmp_pkg.
module wbmp_back import wbmp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_not_empty,
    input  wbmp_cmd_t q_head,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    wbmp_cmd_t           cmd_reg;
    logic                busy_reg;
    logic [IDX_BITS-1:0] idx_reg;
    logic                m_valid_reg;
    out_item_t           m_data_reg;

    logic                emit, emit_last;
    out_item_t           res;

    assign emit      = busy_reg && (!m_valid_reg || m_ready);
    assign emit_last = emit && (({1'b0, idx_reg} + CNT_BITS'(1)) == cmd_reg.count);
    assign q_pop     = q_not_empty && (!busy_reg || emit_last);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        res             = '0;
        res.result_kind = cmd_reg.is_err;
        res.error_code  = cmd_reg.err_code;
        // bits go out MSB first
        res.pixel       = cmd_reg.data_byte[IDX_BITS'(7) - idx_reg];
        res.column      = cmd_reg.column + COORD_BITS'(idx_reg);
        res.row         = cmd_reg.row;
        res.last_of_run = emit_last;
        res.image_done  = emit_last && cmd_reg.image_done;
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= res;
        end
        if (q_pop) begin
            cmd_reg <= q_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (emit_last) begin
                busy_reg <= 1'b0;
            end else if (emit) begin
                idx_reg <= idx_reg + IDX_BITS'(1);
            end

            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: hw/rtl/wbmp_type0_decoder_top.sv
// Top level of the WBMP type 0 decoder: limit register, parser, command
// queue and unpacker. Depends on wbmp_pkg, wbmp_front, wbmp_cmd_fifo, wbmp_back.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------
//  s_      | in        | s_valid / s_ready   | in_item_t (file byte)
//  m_      | out       | m_valid / m_ready   | out_item_t (pixel / error)
//  cfg_    | in        | cfg_valid/cfg_ready | max_dimension, 20 bits
//
// Header bytes are accepted while the command queue is not full. A pixel byte
// is parsed into one command and then unpacked at one pixel per cycle while
// m_ready allows, through the single-result output register. A 4-entry command
// queue lets the parser run ahead of the unpacker. Synchronous active-low reset;
// the limit resets to 524288. cfg_ready is always high.
module wbmp_type0_decoder_top import wbmp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_BITS-1:0] cfg_data
);

    localparam int XW = (DIM_BITS > CFG_BITS) ? DIM_BITS : CFG_BITS;
    localparam logic [XW-1:0] CAP = XW'(1) << COORD_BITS;

    logic [CFG_BITS-1:0] max_dim_reg;
    logic [XW-1:0]       max_dim_x, limit_x;
    logic [DIM_BITS-1:0] limit;

    logic                q_push, q_pop, q_full, q_not_empty;
    wbmp_cmd_t           q_cmd, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dim_reg <= MAX_DIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_dim_reg <= cfg_data;
        end
    end

    // limit in force keeps coordinates inside their fields
    assign max_dim_x = XW'(max_dim_reg);
    assign limit_x   = (max_dim_x < CAP) ? max_dim_x : CAP;
    assign limit     = limit_x[DIM_BITS-1:0];

    wbmp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .limit   (limit),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    wbmp_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .pop       (q_pop),
        .head_cmd  (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    wbmp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
